FILE: rtl/odh_pkg.sv
// shared types, constants and arithmetic helpers for the omni drive heading block
package odh_pkg;

  // fixed-point formats
  localparam int TRIG_FRAC_BITS = 14;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int SUM_FRAC_BITS  = 16;

  // shifts that bring every term into the common Q32 sum
  localparam int MIX_SHIFT = 32 - 2 * TRIG_FRAC_BITS;
  localparam int P_SHIFT   = 32 - GAIN_FRAC_BITS;
  localparam int I_SHIFT   = 32 - GAIN_FRAC_BITS - SUM_FRAC_BITS;

  // datapath widths
  localparam int A_W    = 28;
  localparam int B_W    = 16;
  localparam int PROD_W = A_W + B_W;
  localparam int PID_W  = 60;
  localparam int SUM_W  = 28;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam logic signed [PID_W-1:0] WHEEL_LIM = 60'sd255 <<< 32;

  // register indexes
  typedef enum logic [1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1,
    REG_DERIV = 2'd2
  } odh_reg_t;

  // multiply steps of one item
  typedef enum logic [2:0] {
    OP_VX    = 3'd0,
    OP_VY    = 3'd1,
    OP_MIX1  = 3'd2,
    OP_MIX2  = 3'd3,
    OP_PROP  = 3'd4,
    OP_DERIV = 3'd5,
    OP_INTEG = 3'd6
  } odh_op_t;

  typedef struct packed {
    logic signed [15:0] prop;
    logic signed [15:0] integ;
    logic signed [15:0] deriv;
  } odh_gains_t;

  typedef struct packed {
    logic                  start;
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
  } odh_mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } odh_mul_rsp_t;

  typedef logic [15:0] sin_tab_t [0:90];

  // first-quadrant sine in Q.TRIG, built from a Q30 taylor series at elaboration
  function automatic sin_tab_t gen_sin_tab();
    sin_tab_t          tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            acc;
    for (int k = 0; k <= 90; k++) begin
      x    = (longint'(k) * PI_Q30) / 180;
      x2   = (x * x) >> 30;
      acc  = longint'(x);
      // odd powers up to x^15, each term divided by 2n(2n+1)
      term = ((x * x2) >> 30) / 6;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 20;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 42;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 72;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 110;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 156;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 210;
      acc  = acc - longint'(term);
      if (acc < 0) begin
        acc = 0;
      end
      tab[k] = 16'((acc + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS));
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = gen_sin_tab();
  localparam logic signed [B_W-1:0] S45 = SIN_TAB[45];

  // sine of a whole-degree angle below 360, by quadrant symmetry
  function automatic logic signed [15:0] sin_deg(logic [8:0] k);
    logic [8:0]         red;
    logic               neg;
    logic signed [15:0] val;
    if (k <= 9'd90) begin
      red = k;
      neg = 1'b0;
    end else if (k <= 9'd180) begin
      red = 9'd180 - k;
      neg = 1'b0;
    end else if (k <= 9'd270) begin
      red = k - 9'd180;
      neg = 1'b1;
    end else begin
      red = 9'd360 - k;
      neg = 1'b1;
    end
    val = SIN_TAB[red[6:0]];
    return neg ? -val : val;
  endfunction

  // saturate the leaky integral to its 28-bit range
  function automatic logic signed [SUM_W-1:0] sat_sum(logic signed [SUM_W:0] v);
    logic signed [SUM_W:0] hi;
    logic signed [SUM_W:0] lo;
    hi = (SUM_W+1)'((64'sd1 <<< (SUM_W - 1)) - 1);
    lo = -(SUM_W+1)'(64'sd1 <<< (SUM_W - 1));
    if (v > hi) begin
      return hi[SUM_W-1:0];
    end else if (v < lo) begin
      return lo[SUM_W-1:0];
    end
    return v[SUM_W-1:0];
  endfunction

  // add the pid term to a mix term, clamp to +-255 and truncate toward zero
  function automatic logic signed [8:0] sat_wheel(logic signed [PROD_W-1:0] m,
                                                  logic signed [PID_W-1:0] pid);
    logic signed [PID_W-1:0] t;
    logic signed [PID_W-1:0] mag;
    logic signed [8:0]       res;
    t = (PID_W'(m) <<< MIX_SHIFT) + pid;
    if (t > WHEEL_LIM) begin
      t = WHEEL_LIM;
    end else if (t < -WHEEL_LIM) begin
      t = -WHEEL_LIM;
    end
    mag = (t < 0) ? -t : t;
    res = {1'b0, mag[39:32]};
    return (t < 0) ? -res : res;
  endfunction

endpackage

FILE: rtl/odh_if.sv
// item channels of the omni drive heading block

interface odh_in_if;
  logic               valid;
  logic               ready;
  logic [8:0]         travel_dir;
  logic [7:0]         travel_speed;
  logic [8:0]         heading_now;
  logic signed [10:0] heading_offset;
  logic [3:0]         block_flags;
  logic               unblock_allowed;
  logic               unlock_timeout;

  modport source (output valid, travel_dir, travel_speed, heading_now, heading_offset,
                  block_flags, unblock_allowed, unlock_timeout, input ready);
  modport sink (input valid, travel_dir, travel_speed, heading_now, heading_offset,
                block_flags, unblock_allowed, unlock_timeout, output ready);
endinterface

interface odh_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] wheel_one;
  logic signed [8:0] wheel_two;
  logic signed [8:0] wheel_three;
  logic signed [8:0] wheel_four;
  logic              flags_cleared;

  modport source (output valid, wheel_one, wheel_two, wheel_three, wheel_four,
                  flags_cleared, input ready);
  modport sink (input valid, wheel_one, wheel_two, wheel_three, wheel_four,
                flags_cleared, output ready);
endinterface

FILE: rtl/odh_serial_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
module odh_serial_mul
  import odh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  odh_mul_req_t req,
  output odh_mul_rsp_t rsp
);

  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic signed [PROD_W-1:0] a_sh_r;
  logic [B_W-1:0]           b_r;
  logic [3:0]               cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic signed [PROD_W-1:0] addend;

  // partial product of the current bit, the top bit carries negative weight
  always_comb begin
    addend = '0;
    if (b_r[0]) begin
      addend = (cnt_r == 4'(B_W - 1)) ? -a_sh_r : a_sh_r;
    end
    acc_nxt = acc_r + addend;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand shift registers and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r  <= '0;
      a_sh_r <= PROD_W'(req.a);
      b_r    <= req.b;
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      a_sh_r <= a_sh_r <<< 1;
      b_r    <= b_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

FILE: rtl/odh_apb_regs.sv
// gain registers behind the apb-style configuration port
module odh_apb_regs
  import odh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output odh_gains_t  gains
);

  odh_gains_t gains_r;
  odh_reg_t   idx;

  assign idx = odh_reg_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_PROP:  gains_r.prop  <= pwdata[15:0];
        REG_INTEG: gains_r.integ <= pwdata[15:0];
        REG_DERIV: gains_r.deriv <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back, sign extended
  always_comb begin
    unique case (idx)
      REG_PROP:  prdata = 32'(gains_r.prop);
      REG_INTEG: prdata = 32'(gains_r.integ);
      REG_DERIV: prdata = 32'(gains_r.deriv);
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign gains  = gains_r;

endmodule

FILE: rtl/omni_drive_heading_pid_top.sv
// omni drive mixer with pid heading hold: sequencer, datapath and state
// one item at a time: each takes seven 16-bit passes of the single bit-serial
//   multiplier, then the output step, before the next item can be accepted
// the next item is taken while a finished result waits at the output register
// reset (rst_n low, synchronous) clears gains, last error, leaky integral, handshakes
module omni_drive_heading_pid_top
  import odh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  odh_in_if.sink      in_if,
  odh_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_FIN    = 4'b1000
  } odh_state_t;

  odh_state_t state_r, state_nxt;
  odh_op_t    op_r;

  odh_gains_t   gains;
  odh_mul_req_t mreq;
  odh_mul_rsp_t mrsp;

  // item registers
  logic signed [15:0]       sin_r, cos_r;
  logic [7:0]               spd_r;
  logic [3:0]               flags_r;
  logic                     unblock_r, timeout_r;
  logic signed [10:0]       delta_r;
  logic signed [11:0]       diff_r;
  logic signed [22:0]       vx_r, vy_r;
  logic signed [PROD_W-1:0] m1_r, m2_r;
  logic signed [PID_W-1:0]  pid_r;

  // state across items
  logic signed [10:0]      last_err_r;
  logic signed [SUM_W-1:0] leaky_r;

  // output register
  logic              out_valid_r;
  logic signed [8:0] w1_r, w2_r, w3_r, w4_r;
  logic              clr_r;

  // accept-time front end
  logic               in_acc;
  logic [8:0]         dir_fix, dir_cos;
  logic signed [11:0] off_w;
  logic signed [9:0]  head_s;
  logic signed [10:0] delta;
  logic signed [SUM_W:0] sum_raw;

  // block handling
  logic               away, cleared;
  logic [3:0]         fl_eff;
  logic signed [22:0] vx_eff, vy_eff;

  logic signed [PID_W-1:0] term;

  odh_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains   (gains)
  );

  odh_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  // direction, offset wrap and heading error
  always_comb begin
    dir_fix = (in_if.travel_dir >= 9'd360) ? in_if.travel_dir - 9'd360 : in_if.travel_dir;
    dir_cos = (dir_fix >= 9'd270) ? dir_fix - 9'd270 : dir_fix + 9'd90;
    off_w   = 12'(in_if.heading_offset);
    for (int i = 0; i < 3; i++) begin
      if (off_w < -12'sd180) begin
        off_w = off_w + 12'sd360;
      end else if (off_w > 12'sd180) begin
        off_w = off_w - 12'sd360;
      end
    end
    head_s = (in_if.heading_now > 9'd180) ? 10'(in_if.heading_now) - 10'sd360
                                          : 10'(in_if.heading_now);
    delta   = 11'(head_s) - off_w[10:0];
    sum_raw = (SUM_W+1)'(leaky_r >>> 1) + ((SUM_W+1)'(delta) <<< SUM_FRAC_BITS);
  end

  // wall-block clearing and axis zeroing
  always_comb begin
    away = (vy_r < 0 && flags_r[0]) || (vy_r > 0 && flags_r[1]) ||
           (vx_r < 0 && flags_r[2]) || (vx_r > 0 && flags_r[3]);
    cleared = (away && unblock_r) || timeout_r;
    fl_eff  = cleared ? 4'd0 : flags_r;
    vy_eff  = vy_r;
    vx_eff  = vx_r;
    if ((vy_r > 0 && fl_eff[0]) || (vy_r < 0 && fl_eff[1])) begin
      vy_eff = '0;
    end
    if ((vx_r > 0 && fl_eff[2]) || (vx_r < 0 && fl_eff[3])) begin
      vx_eff = '0;
    end
  end

  // multiplier operands per step
  always_comb begin
    mreq.start = (state_r == ST_LAUNCH);
    mreq.a     = '0;
    mreq.b     = '0;
    unique case (op_r)
      OP_VX: begin
        mreq.a = A_W'(cos_r);
        mreq.b = B_W'(spd_r);
      end
      OP_VY: begin
        mreq.a = A_W'(sin_r);
        mreq.b = B_W'(spd_r);
      end
      OP_MIX1: begin
        mreq.a = A_W'(vx_eff) + A_W'(vy_eff);
        mreq.b = S45;
      end
      OP_MIX2: begin
        mreq.a = A_W'(vx_eff) - A_W'(vy_eff);
        mreq.b = S45;
      end
      OP_PROP: begin
        mreq.a = A_W'(delta_r);
        mreq.b = gains.prop;
      end
      OP_DERIV: begin
        mreq.a = A_W'(diff_r);
        mreq.b = gains.deriv;
      end
      OP_INTEG: begin
        mreq.a = leaky_r;
        mreq.b = gains.integ;
      end
      default: ;
    endcase
  end

  // pid term of the finished product, scaled to Q32
  always_comb begin
    if (op_r == OP_INTEG) begin
      term = PID_W'(mrsp.prod) <<< I_SHIFT;
    end else begin
      term = PID_W'(mrsp.prod) <<< P_SHIFT;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (mrsp.done) begin
          state_nxt = (op_r == OP_INTEG) ? ST_FIN : ST_LAUNCH;
        end
      end
      ST_FIN:    if (!out_valid_r || out_if.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_VX;
      out_valid_r <= 1'b0;
      last_err_r  <= '0;
      leaky_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && (!out_valid_r || out_if.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        op_r       <= OP_VX;
        last_err_r <= delta;
        leaky_r    <= sat_sum(sum_raw);
      end
      if (state_r == ST_WAIT && mrsp.done && op_r != OP_INTEG) begin
        op_r <= odh_op_t'(op_r + 3'd1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sin_r     <= sin_deg(dir_fix);
      cos_r     <= sin_deg(dir_cos);
      spd_r     <= in_if.travel_speed;
      flags_r   <= in_if.block_flags;
      unblock_r <= in_if.unblock_allowed;
      timeout_r <= in_if.unlock_timeout;
      delta_r   <= delta;
      diff_r    <= 12'(delta) - 12'(last_err_r);
    end
    if (state_r == ST_WAIT && mrsp.done) begin
      unique case (op_r)
        OP_VX:    vx_r  <= mrsp.prod[22:0];
        OP_VY:    vy_r  <= -mrsp.prod[22:0];
        OP_MIX1:  m1_r  <= mrsp.prod;
        OP_MIX2:  m2_r  <= mrsp.prod;
        OP_PROP:  pid_r <= term;
        OP_DERIV: pid_r <= pid_r + term;
        OP_INTEG: pid_r <= pid_r + term;
        default: ;
      endcase
    end
    if (state_r == ST_FIN && (!out_valid_r || out_if.ready)) begin
      w1_r  <= sat_wheel(m1_r, pid_r);
      w2_r  <= sat_wheel(m2_r, pid_r);
      w3_r  <= sat_wheel(-m1_r, pid_r);
      w4_r  <= sat_wheel(-m2_r, pid_r);
      clr_r <= cleared;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.wheel_one     = w1_r;
  assign out_if.wheel_two     = w2_r;
  assign out_if.wheel_three   = w3_r;
  assign out_if.wheel_four    = w4_r;
  assign out_if.flags_cleared = clr_r;

endmodule

FILE: rtl/odh_checker.sv
// port-level checks of the omni drive heading block, bound to the top level
module odh_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [8:0] wheel_one,
  input logic signed [8:0] wheel_three
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // one item at a time: no new item right after one is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // no result appears in the cycle right after an item is taken
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result item too early");

  // wheels stay inside the saturation limits
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (wheel_one != -9'sd256) && (wheel_three != -9'sd256))
    else $error("wheel value outside +-255");

endmodule

bind omni_drive_heading_pid_top odh_checker u_odh_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .wheel_one   (out_if.wheel_one),
  .wheel_three (out_if.wheel_three)
);
